FILE: sv/k_way_merge_streams_unit_macros.svh
// assertion helpers, clocked on aclk and disabled while aresetn is low
`ifndef K_WAY_MERGE_STREAMS_UNIT_MACROS_SVH
`define K_WAY_MERGE_STREAMS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define KWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define KWM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`else

`define KWM_ASSERT(lbl, prop, msg)

`define KWM_NEVER(lbl, cond, msg)

`endif

`endif

FILE: sv/kwm_pkg.sv
`default_nettype none

package kwm_pkg;

    localparam int MAX_LISTS   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int LIST_W      = $clog2(MAX_LISTS);
    localparam int COUNT_W     = $clog2(MAX_LISTS + 1);

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_HOLD  = 2'd1;
    localparam logic [1:0] SLOT_END   = 2'd2;

    // flipping the sign bit turns signed order into unsigned order
    localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [LIST_W-1:0]             list_number;
        logic signed [VALUE_WIDTH-1:0] element_value;
        logic                          list_ended;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] merged_value;
        logic [LIST_W-1:0]             source_list;
        logic                          merge_done;
        logic                          bad_input;
    } out_item_t;

    // running minimum carried along the row of cells
    typedef struct packed {
        logic                   valid;
        logic                   found;
        logic                   ready;
        logic [VALUE_WIDTH-1:0] key;
        logic [LIST_W-1:0]      idx;
    } scan_t;

    typedef struct packed {
        logic       load;
        logic [1:0] load_status;
        logic       clear;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/kwm_cell.sv
`default_nettype none

module kwm_cell (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   active,
    input  wire logic [kwm_pkg::LIST_W-1:0]             cell_index,
    input  wire kwm_pkg::cell_ctl_t                     ctl,
    input  wire logic signed [kwm_pkg::VALUE_WIDTH-1:0] wr_value,
    input  wire kwm_pkg::scan_t                         scan_in,
    output kwm_pkg::scan_t                              scan_out,
    output logic [1:0]                                  status
);

    logic [1:0]                      status_reg;
    logic [kwm_pkg::VALUE_WIDTH-1:0] key_reg;
    kwm_pkg::scan_t                  scan_reg;
    kwm_pkg::scan_t                  scan_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= kwm_pkg::SLOT_EMPTY;
        end else if (ctl.clear) begin
            status_reg <= kwm_pkg::SLOT_EMPTY;
        end else if (ctl.load) begin
            status_reg <= ctl.load_status;
        end
    end

    // head kept in offset-binary form
    always_ff @(posedge aclk) begin
        if (ctl.load && ctl.load_status == kwm_pkg::SLOT_HOLD) begin
            key_reg <= wr_value ^ kwm_pkg::SIGN_FLIP;
        end
    end

    always_comb begin
        scan_next = scan_in;
        if (scan_in.valid && active) begin
            if (status_reg == kwm_pkg::SLOT_EMPTY) begin
                scan_next.ready = 1'b0;
            end else if (status_reg == kwm_pkg::SLOT_HOLD) begin
                // strict compare keeps the lower index on ties
                if (!scan_in.found || key_reg < scan_in.key) begin
                    scan_next.found = 1'b1;
                    scan_next.key   = key_reg;
                    scan_next.idx   = cell_index;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
        end else begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire

FILE: sv/k_way_merge_streams_unit.sv
// k-way merge of up to 16 ascending signed 32-bit streams. Each request on s_ carries the
// next element of one list or its end marker; once every list in use holds a head or has
// ended, the smallest head (lower list on ties) comes out on m_ and source_list names the
// list to refill. When every list in use has ended a merge_done result comes out and all
// slots clear. A request for a list beyond lists_in_use or for a slot already filled comes
// back with bad_input set and changes nothing. The heads live in a row of 16 cells and the
// minimum search travels down that row one cell per clock, the first cell working in the
// launch cycle. A stored request has its answer captured in the output register when the
// search leaves the last cell; a bad request is answered at the edge that accepts it.
// Only one request is in flight, and the next is taken once the search is over and any
// result has left the output register. lists_in_use is written through cfg_ and values
// above 16 count as 16.
`default_nettype none

`include "k_way_merge_streams_unit_macros.svh"

module k_way_merge_streams_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kwm_pkg::COUNT_W-1:0]     cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire kwm_pkg::in_item_t               s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output kwm_pkg::out_item_t                   m_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic                          launch_reg;
    logic                          launch_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    kwm_pkg::out_item_t            out_reg;
    kwm_pkg::out_item_t            out_next;
    logic [kwm_pkg::COUNT_W-1:0]   lists_reg;
    logic [kwm_pkg::COUNT_W-1:0]   count_eff;

    kwm_pkg::scan_t                chain [kwm_pkg::MAX_LISTS+1];
    kwm_pkg::cell_ctl_t            ctl [kwm_pkg::MAX_LISTS];
    logic [1:0]                    status_arr [kwm_pkg::MAX_LISTS];
    logic [kwm_pkg::MAX_LISTS-1:0] active;
    logic [kwm_pkg::MAX_LISTS:0]   token_vec;

    logic                          s_accept;
    logic                          bad;
    logic                          scan_done;
    logic                          take;
    logic                          clear_all;
    logic                          all_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lists_reg <= kwm_pkg::COUNT_W'(kwm_pkg::MAX_LISTS);
        end else if (cfg_valid && cfg_ready) begin
            lists_reg <= cfg_data;
        end
    end

    assign count_eff = (lists_reg > kwm_pkg::COUNT_W'(kwm_pkg::MAX_LISTS))
                     ? kwm_pkg::COUNT_W'(kwm_pkg::MAX_LISTS) : lists_reg;

    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign bad      = ({1'b0, s_data.list_number} >= count_eff)
                   || (status_arr[s_data.list_number] != kwm_pkg::SLOT_EMPTY);

    assign chain[0] = '{valid: launch_reg, found: 1'b0, ready: 1'b1,
                        key: '0, idx: '0};

    assign scan_done = (state_reg == ST_SCAN) && chain[kwm_pkg::MAX_LISTS].valid;
    assign take      = scan_done && chain[kwm_pkg::MAX_LISTS].ready
                    && chain[kwm_pkg::MAX_LISTS].found;
    assign clear_all = scan_done && chain[kwm_pkg::MAX_LISTS].ready
                    && !chain[kwm_pkg::MAX_LISTS].found;

    genvar gi;
    generate
        for (gi = 0; gi < kwm_pkg::MAX_LISTS; gi++) begin : g_cell
            assign active[gi] = kwm_pkg::COUNT_W'(gi) < count_eff;

            always_comb begin
                ctl[gi].load        = s_accept && !bad
                                   && (s_data.list_number == kwm_pkg::LIST_W'(gi));
                ctl[gi].load_status = s_data.list_ended ? kwm_pkg::SLOT_END
                                                        : kwm_pkg::SLOT_HOLD;
                ctl[gi].clear       = clear_all
                                   || (take && chain[kwm_pkg::MAX_LISTS].idx
                                               == kwm_pkg::LIST_W'(gi));
            end

            kwm_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .active     (active[gi]),
                .cell_index (kwm_pkg::LIST_W'(gi)),
                .ctl        (ctl[gi]),
                .wr_value   (s_data.element_value),
                .scan_in    (chain[gi]),
                .scan_out   (chain[gi+1]),
                .status     (status_arr[gi])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i <= kwm_pkg::MAX_LISTS; i++) begin
            token_vec[i] = chain[i].valid;
        end
    end

    always_comb begin
        all_empty = 1'b1;
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
            if (status_arr[i] != kwm_pkg::SLOT_EMPTY) begin
                all_empty = 1'b0;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        launch_next  = 1'b0;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (bad) begin
                        m_valid_next          = 1'b1;
                        out_next.merged_value = '0;
                        out_next.source_list  = s_data.list_number;
                        out_next.merge_done   = 1'b0;
                        out_next.bad_input    = 1'b1;
                    end else begin
                        state_next  = ST_SCAN;
                        launch_next = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_IDLE;
                    if (take) begin
                        m_valid_next          = 1'b1;
                        out_next.merged_value = chain[kwm_pkg::MAX_LISTS].key
                                              ^ kwm_pkg::SIGN_FLIP;
                        out_next.source_list  = chain[kwm_pkg::MAX_LISTS].idx;
                        out_next.merge_done   = 1'b0;
                        out_next.bad_input    = 1'b0;
                    end else if (clear_all) begin
                        m_valid_next          = 1'b1;
                        out_next.merged_value = '0;
                        out_next.source_list  = '0;
                        out_next.merge_done   = 1'b1;
                        out_next.bad_input    = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `KWM_ASSERT(a_launch_after_store, s_accept && !bad |=> launch_reg, "store did not launch scan")
    `KWM_ASSERT(a_one_token, $onehot0(token_vec), "more than one scan token in the row")
    `KWM_ASSERT(a_end_in_scan, chain[kwm_pkg::MAX_LISTS].valid |-> state_reg == ST_SCAN, "scan ended outside scan state")
    `KWM_ASSERT(a_done_clears, clear_all |=> all_empty, "done result left a slot filled")
    `KWM_NEVER(a_load_while_full, (take || clear_all || (s_accept && bad)) && m_valid_reg, "result overwrote a waiting result")

endmodule

`default_nettype wire
